FILE: src/aml_sleep_type_scanner_top_defines.svh
// Assertion macros for the sleep type scanner.
`ifndef AML_SLEEP_TYPE_SCANNER_TOP_DEFINES_SVH
`define AML_SLEEP_TYPE_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define AML_SST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define AML_SST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/aml_sst_pkg.sv
// Package with the types and constants of the sleep type scanner.
`default_nettype none

package aml_sst_pkg;

   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned TYPE_WIDTH = 3;
   localparam int unsigned SIG_WIDTH  = 32;

   localparam logic [SIG_WIDTH-1:0] SIGNATURE_RESET = 32'h5F35_535F;

   localparam logic [BYTE_WIDTH-1:0] NAME_OP     = 8'h08;
   localparam logic [BYTE_WIDTH-1:0] ROOT_PREFIX = 8'h5C;
   localparam logic [BYTE_WIDTH-1:0] PACKAGE_OP  = 8'h12;
   localparam logic [BYTE_WIDTH-1:0] BYTE_PREFIX = 8'h0A;

   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [TYPE_WIDTH-1:0] sleep_type_type;
   typedef logic [SIG_WIDTH-1:0]  signature_type;

   typedef enum logic [1:0] {
      STATUS_NOT_FOUND = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_CUT_SHORT = 2'd2
   } scan_status_type;

endpackage

`default_nettype wire

FILE: src/aml_sst_if.sv
// Channel interfaces of the sleep type scanner: byte requests, results, register writes.
`default_nettype none

interface aml_sst_req_if import aml_sst_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type aml_byte;
   logic     last_byte;

   modport source (output valid, output aml_byte, output last_byte, input ready);
   modport sink   (input valid, input aml_byte, input last_byte, output ready);
endinterface

interface aml_sst_rsp_if import aml_sst_pkg::*; ();
   logic            valid;
   logic            ready;
   scan_status_type scan_status;
   sleep_type_type  sleep_type_a;
   sleep_type_type  sleep_type_b;

   modport source (output valid, output scan_status, output sleep_type_a,
                   output sleep_type_b, input ready);
   modport sink   (input valid, input scan_status, input sleep_type_a,
                   input sleep_type_b, output ready);
endinterface

interface aml_sst_csr_if import aml_sst_pkg::*; ();
   logic          valid;
   logic          ready;
   signature_type name_signature;

   modport source (output valid, output name_signature, input ready);
   modport sink   (input valid, input name_signature, output ready);
endinterface

`default_nettype wire

FILE: src/aml_sleep_type_scanner_top.sv
// Sleep type scanner: finds a named package in a table byte stream and reports its two values.
//
// The scanner takes one table byte per clock cycle, with no gaps, as long as results are
// taken. Each byte goes through an input register, then through one pass of the window
// compare and phase logic, and a result lands in the output register: a result is presented
// once its byte has passed the input register, or later while an earlier result still
// waits to be taken. One result is given per table, either on the byte that completes the
// second package value or on the byte marked last. Register writes are taken at any time,
// but belong between transactions: a byte still waiting in the input register is compared
// with the new name.
`default_nettype none

`include "aml_sleep_type_scanner_top_defines.svh"

module aml_sleep_type_scanner_top import aml_sst_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   aml_sst_req_if.sink    req_chan,
   aml_sst_rsp_if.source  rsp_chan,
   aml_sst_csr_if.sink    csr_chan
);

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_LEAD,
      PH_SKIP,
      PH_A,
      PH_A_VAL,
      PH_B,
      PH_B_VAL,
      PH_DONE
   } phase_type;

   signature_type   sig_ff;
   logic            in_vld_ff;
   byte_type        in_byte_ff;
   logic            in_last_ff;
   logic [47:0]     window_ff,  window_in;
   phase_type       phase_ff,   phase_in;
   logic [2:0]      skip_ff,    skip_in;
   sleep_type_type  first_ff,   first_in;
   logic            rsp_vld_ff, rsp_vld_in;
   scan_status_type status_ff,  status_in;
   sleep_type_type  type_a_ff,  type_a_in;
   sleep_type_type  type_b_ff,  type_b_in;

   logic advance;
   logic consume;
   logic emit;
   logic name_hit;
   logic header_hit;

   assign advance = !rsp_vld_ff || rsp_chan.ready;
   assign consume = in_vld_ff && advance;

   assign req_chan.ready = !in_vld_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.scan_status  = status_ff;
   assign rsp_chan.sleep_type_a = type_a_ff;
   assign rsp_chan.sleep_type_b = type_b_ff;

   // The window holds the newest byte in its low bits, so the name reads byte-reversed.
   assign name_hit = (window_ff[31:24] == sig_ff[7:0])   &&
                     (window_ff[23:16] == sig_ff[15:8])  &&
                     (window_ff[15:8]  == sig_ff[23:16]) &&
                     (window_ff[7:0]   == sig_ff[31:24]);

   assign header_hit = name_hit &&
      ((window_ff[39:32] == NAME_OP && window_ff[31:24] != ROOT_PREFIX) ||
       (window_ff[47:40] == NAME_OP && window_ff[39:32] == ROOT_PREFIX));

   always_comb begin
      phase_in  = phase_ff;
      skip_in   = skip_ff;
      first_in  = first_ff;
      window_in = {window_ff[39:0], in_byte_ff};
      emit      = 1'b0;
      status_in = STATUS_FOUND;
      type_a_in = first_ff;
      type_b_in = in_byte_ff[TYPE_WIDTH-1:0];

      unique case (phase_ff)
         PH_SEARCH: begin
            if (in_byte_ff == PACKAGE_OP && header_hit) begin
               phase_in = PH_LEAD;
            end
         end
         PH_LEAD: begin
            skip_in  = {1'b0, in_byte_ff[7:6]} + 3'd1;
            phase_in = PH_SKIP;
         end
         PH_SKIP: begin
            skip_in = skip_ff - 3'd1;
            if (skip_in == 3'd0) begin
               phase_in = PH_A;
            end
         end
         PH_A: begin
            if (in_byte_ff == BYTE_PREFIX) begin
               phase_in = PH_A_VAL;
            end else begin
               first_in = in_byte_ff[TYPE_WIDTH-1:0];
               phase_in = PH_B;
            end
         end
         PH_A_VAL: begin
            first_in = in_byte_ff[TYPE_WIDTH-1:0];
            phase_in = PH_B;
         end
         PH_B, PH_B_VAL: begin
            if (phase_ff == PH_B && in_byte_ff == BYTE_PREFIX) begin
               phase_in = PH_B_VAL;
            end else begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // The last byte of a table closes the scan and returns all scan state to reset.
      if (in_last_ff) begin
         if (!emit && phase_in != PH_DONE) begin
            emit      = 1'b1;
            status_in = (phase_in == PH_SEARCH) ? STATUS_NOT_FOUND : STATUS_CUT_SHORT;
            type_a_in = '0;
            type_b_in = '0;
         end
         phase_in  = PH_SEARCH;
         skip_in   = '0;
         first_in  = '0;
         window_in = '0;
      end

      rsp_vld_in = (consume && emit) || (rsp_vld_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff     <= SIGNATURE_RESET;
         in_vld_ff  <= 1'b0;
         window_ff  <= '0;
         phase_ff   <= PH_SEARCH;
         skip_ff    <= '0;
         first_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            sig_ff <= csr_chan.name_signature;
         end
         if (req_chan.ready) begin
            in_vld_ff  <= req_chan.valid;
            in_byte_ff <= req_chan.aml_byte;
            in_last_ff <= req_chan.last_byte;
         end
         if (consume) begin
            window_ff <= window_in;
            phase_ff  <= phase_in;
            skip_ff   <= skip_in;
            first_ff  <= first_in;
         end
         rsp_vld_ff <= rsp_vld_in;
         if (consume && emit) begin
            status_ff <= status_in;
            type_a_ff <= type_a_in;
            type_b_ff <= type_b_in;
         end
      end
   end

   `AML_SST_ASSERT_NOW(a_types_zero_unless_found,
      rsp_chan.valid && rsp_chan.scan_status != STATUS_FOUND,
      rsp_chan.sleep_type_a == '0 && rsp_chan.sleep_type_b == '0,
      "Sleep types are nonzero in a result that is not found.")
   `AML_SST_ASSERT_NOW(a_done_is_silent,
      consume && phase_ff == PH_DONE && !in_last_ff, !emit,
      "A result was produced after the table's result was already given.")
   `AML_SST_ASSERT_NEXT(a_last_clears_scan,
      consume && in_last_ff, phase_ff == PH_SEARCH && window_ff == '0 && skip_ff == '0,
      "Scan state did not return to reset after the last byte of a table.")
   `AML_SST_ASSERT_NOW(a_stall_only_when_full,
      !req_chan.ready, in_vld_ff && rsp_vld_ff,
      "Byte requests were stalled with a free register stage.")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench for the sleep type scanner: directed and random tables, checked against a predictor.
`timescale 1ns / 100ps

module tb import aml_sst_pkg::*; ();

   typedef enum logic [2:0] {
      SCAN_SEARCH,
      SCAN_LEAD,
      SCAN_SKIP,
      SCAN_A,
      SCAN_A_VALUE,
      SCAN_B,
      SCAN_B_VALUE,
      SCAN_DONE
   } scan_phase_type;

   typedef struct packed {
      scan_status_type status;
      sleep_type_type  type_a;
      sleep_type_type  type_b;
   } scan_result_type;

   logic clock;
   logic reset = 1'b1;

   aml_sst_req_if req_chan ();
   aml_sst_rsp_if rsp_chan ();
   aml_sst_csr_if csr_chan ();

   aml_sleep_type_scanner_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predictor copy of the register and the scan state.
   signature_type  name_sig    = SIGNATURE_RESET;
   logic [47:0]    byte_window = '0;
   scan_phase_type scan_phase  = SCAN_SEARCH;
   logic [2:0]     skip_left   = '0;
   sleep_type_type first_type  = '0;

   scan_result_type expected_scans[$];

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int failures      = 0;
   int bytes_sent    = 0;
   int scans_checked = 0;
   int sig_writes    = 0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial begin
      #2_000_000;
      $display("aml_sleep_type_scanner_top test failed");
      $finish;
   end

   // Advances the scan by one byte; returns 1 when the byte produces a result.
   function automatic bit scan_next_byte(input byte_type b, input logic is_last,
                                         output scan_result_type res);
      bit got;
      bit name_hit;
      bit direct_hit;
      bit rooted_hit;
      got = 1'b0;
      res = '{STATUS_NOT_FOUND, 3'd0, 3'd0};
      name_hit = name_sig == {byte_window[7:0], byte_window[15:8],
                              byte_window[23:16], byte_window[31:24]};
      direct_hit = byte_window[39:32] == NAME_OP && byte_window[31:24] != ROOT_PREFIX;
      rooted_hit = byte_window[47:40] == NAME_OP && byte_window[39:32] == ROOT_PREFIX;
      case (scan_phase)
         SCAN_SEARCH: begin
            if (b == PACKAGE_OP && name_hit && (direct_hit || rooted_hit))
               scan_phase = SCAN_LEAD;
         end
         SCAN_LEAD: begin
            skip_left  = {1'b0, b[7:6]} + 3'd1;
            scan_phase = SCAN_SKIP;
         end
         SCAN_SKIP: begin
            skip_left = skip_left - 3'd1;
            if (skip_left == 3'd0)
               scan_phase = SCAN_A;
         end
         SCAN_A: begin
            if (b == BYTE_PREFIX) begin
               scan_phase = SCAN_A_VALUE;
            end else begin
               first_type = b[2:0];
               scan_phase = SCAN_B;
            end
         end
         SCAN_A_VALUE: begin
            first_type = b[2:0];
            scan_phase = SCAN_B;
         end
         SCAN_B, SCAN_B_VALUE: begin
            if (scan_phase == SCAN_B && b == BYTE_PREFIX) begin
               scan_phase = SCAN_B_VALUE;
            end else begin
               res        = '{STATUS_FOUND, first_type, b[2:0]};
               got        = 1'b1;
               scan_phase = SCAN_DONE;
            end
         end
         default: begin
         end
      endcase
      byte_window = {byte_window[39:0], b};
      if (is_last) begin
         if (!got && scan_phase != SCAN_DONE) begin
            res.status = (scan_phase == SCAN_SEARCH) ? STATUS_NOT_FOUND : STATUS_CUT_SHORT;
            got        = 1'b1;
         end
         byte_window = '0;
         scan_phase  = SCAN_SEARCH;
         skip_left   = '0;
         first_type  = '0;
      end
      return got;
   endfunction

   // Biased byte source: opcodes, prefixes and name bytes show up often.
   function automatic byte_type pick_byte();
      case ($urandom_range(7))
         0: return NAME_OP;
         1: return PACKAGE_OP;
         2: return BYTE_PREFIX;
         3: return ROOT_PREFIX;
         4: return name_sig[8 * $urandom_range(3) +: 8];
         default: return byte_type'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin : result_check
      scan_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_scans.size() == 0) begin
            $error("unexpected scan result: scan_status %0d", rsp_chan.scan_status);
            failures++;
         end else begin
            want = expected_scans.pop_front();
            scans_checked++;
            if (rsp_chan.scan_status !== want.status) begin
               $error("scan_status mismatch: expected %0d, actual %0d",
                      want.status, rsp_chan.scan_status);
               failures++;
            end
            if (rsp_chan.sleep_type_a !== want.type_a) begin
               $error("sleep_type_a mismatch: expected %0d, actual %0d",
                      want.type_a, rsp_chan.sleep_type_a);
               failures++;
            end
            if (rsp_chan.sleep_type_b !== want.type_b) begin
               $error("sleep_type_b mismatch: expected %0d, actual %0d",
                      want.type_b, rsp_chan.sleep_type_b);
               failures++;
            end
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_byte(input byte_type b, input logic is_last);
      scan_result_type res;
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.aml_byte  <= b;
      req_chan.last_byte <= is_last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      if (scan_next_byte(b, is_last, res))
         expected_scans.push_back(res);
      bytes_sent++;
   endtask

   task automatic send_table(input byte_type tbl[$]);
      foreach (tbl[i])
         send_byte(tbl[i], i == tbl.size() - 1);
   endtask

   // Stops sending and lets the pipeline empty, including bytes that give no result.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_scans.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_signature(input signature_type sig);
      csr_chan.valid          <= 1'b1;
      csr_chan.name_signature <= sig;
      @(posedge clock);
      while (!csr_chan.ready)
         @(posedge clock);
      csr_chan.valid <= 1'b0;
      name_sig = sig;
      sig_writes++;
   endtask

   // Mostly well-formed headers with random content; some corrupted, cut or pure noise.
   task automatic send_random_table();
      byte_type tbl[$];
      byte_type lead;
      int       cut;
      if ($urandom_range(99) < 75) begin
         repeat ($urandom_range(3)) tbl.push_back(pick_byte());
         tbl.push_back(NAME_OP);
         if ($urandom_range(1))
            tbl.push_back(ROOT_PREFIX);
         for (int i = 0; i < 4; i++)
            tbl.push_back(name_sig[8 * i +: 8]);
         if ($urandom_range(9) == 0)
            tbl[tbl.size() - 1 - $urandom_range(3)] = pick_byte();
         tbl.push_back(PACKAGE_OP);
         lead = byte_type'($urandom);
         tbl.push_back(lead);
         repeat (lead[7:6] + 1) tbl.push_back(byte_type'($urandom));
         repeat (2) begin
            if ($urandom_range(1))
               tbl.push_back(BYTE_PREFIX);
            tbl.push_back(pick_byte());
         end
         repeat ($urandom_range(3)) tbl.push_back(pick_byte());
         if ($urandom_range(4) == 0) begin
            cut = $urandom_range(1, tbl.size());
            while (tbl.size() > cut)
               void'(tbl.pop_back());
         end
      end else begin
         repeat ($urandom_range(1, 12)) tbl.push_back(pick_byte());
      end
      send_table(tbl);
   endtask

   task automatic run_tables(input int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes)
         send_random_table();
   endtask

   task automatic test_directed_tables();
      byte_type tbl[$];
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      // Root prefix, four-byte package length, prefixed values, one of them 0x0A itself.
      tbl = {NAME_OP, ROOT_PREFIX, SIGNATURE_RESET[7:0], SIGNATURE_RESET[15:8],
             SIGNATURE_RESET[23:16], SIGNATURE_RESET[31:24], PACKAGE_OP, 8'hC0,
             8'h11, 8'h22, 8'h33, 8'h04, BYTE_PREFIX, BYTE_PREFIX, BYTE_PREFIX,
             8'hFF, 8'h00};
      send_table(tbl);
      // Table ends right after the package opcode's length byte.
      tbl = {NAME_OP, SIGNATURE_RESET[7:0], SIGNATURE_RESET[15:8],
             SIGNATURE_RESET[23:16], SIGNATURE_RESET[31:24], PACKAGE_OP, 8'h05};
      send_table(tbl);
      tbl = {8'hFF};
      send_table(tbl);
      wait_drained();
   endtask

   task automatic test_no_idling();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      write_signature($urandom);
      run_tables(105);
      wait_drained();
   endtask

   task automatic test_sender_idle();
      req_idle_pct  = 69;
      rsp_stall_pct = 0;
      write_signature($urandom);
      run_tables(105);
      wait_drained();
   endtask

   task automatic test_receiver_stall();
      req_idle_pct  = 0;
      rsp_stall_pct = 69;
      write_signature($urandom);
      run_tables(105);
      wait_drained();
   endtask

   task automatic test_both_idle();
      req_idle_pct  = 7;
      rsp_stall_pct = 7;
      write_signature($urandom);
      run_tables(105);
      wait_drained();
   endtask

   task automatic test_signature_extremes();
      signature_type sigs[4];
      sigs = '{32'h0000_0000, 32'hFFFF_FFFF,
               {24'($urandom_range(24'hFF_FFFF)), ROOT_PREFIX}, SIGNATURE_RESET};
      req_idle_pct  = 7;
      rsp_stall_pct = 7;
      foreach (sigs[i]) begin
         write_signature(sigs[i]);
         run_tables(25);
         wait_drained();
      end
   endtask

   // Sender holds off after each table until its result is back.
   task automatic test_pause_until_drained();
      req_idle_pct  = 0;
      rsp_stall_pct = 69;
      repeat (6) begin
         send_random_table();
         wait_drained();
      end
   endtask

   initial begin
      req_chan.valid          <= 1'b0;
      req_chan.aml_byte       <= '0;
      req_chan.last_byte      <= 1'b0;
      csr_chan.valid          <= 1'b0;
      csr_chan.name_signature <= SIGNATURE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_tables();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_signature_extremes();
      test_pause_until_drained();
      wait_drained();
      $display("Scanned %0d table bytes and checked %0d scan results under %0d name signatures,",
               bytes_sent, scans_checked, sig_writes + 1);
      $display("with sender gaps and receiver stalls varied across the run.");
      if (failures == 0)
         $display("aml_sleep_type_scanner_top test passed");
      else
         $display("aml_sleep_type_scanner_top test failed");
      $finish;
   end

endmodule
